// ===== design/q2bqdp_pkg.sv =====
// Package: types, constants and float32 arithmetic for the two-bit quantized dot product.
`timescale 1ns / 1ps
package q2bqdp_pkg;

  localparam logic [31:0] F32_EXP_ALL = 32'h7f80_0000;
  localparam logic [31:0] F32_QNAN_DEF = 32'hffc0_0000;
  localparam logic [31:0] F32_QBIT = 32'h0040_0000;
  localparam logic [7:0] EXP_REBIAS = 8'd112;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SCALE,
    ST_MUL_ACT,
    ST_ADD,
    ST_DONE
  } ctrl_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic mul_scale;
    logic mul_act;
    logic add;
    logic emit;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic last_elem;
    logic row_end;
    logic out_free;
  } dp_stat_t;

  // Weight value (code - 1) as float32
  function automatic logic [31:0] code_weight(logic [1:0] code);
    logic [31:0] w;
    case (code)
      2'd0: w = 32'hbf80_0000;
      2'd1: w = 32'h0000_0000;
      2'd2: w = 32'h3f80_0000;
      2'd3: w = 32'h4000_0000;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

  // Leading zero count of a 48-bit word (48 when zero)
  function automatic logic [5:0] lzc48(logic [47:0] x);
    logic [5:0] n;
    logic found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 0; i < 48; i++) begin
      if (!found && x[47-i]) begin
        n = 6'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // fp16 to float32, exact, subnormals normalized
  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] m;
    logic [10:0] mm;
    logic [3:0] sh;
    logic found;
    logic [31:0] bits;
    ex = h[14:10];
    m = h[9:0];
    sh = 4'd0;
    found = 1'b0;
    mm = {1'b0, m};
    for (int i = 0; i < 10; i++) begin
      if (!found && m[9-i]) begin
        sh = 4'(i + 1);
        found = 1'b1;
      end
    end
    mm = {1'b0, m} << sh;
    if (ex == 5'd0) begin
      if (m == 10'd0) begin
        bits = {h[15], 31'd0};
      end else begin
        bits = {h[15], EXP_REBIAS + 8'd1 - {4'd0, sh}, mm[9:0], 13'd0};
      end
    end else if (ex == 5'h1f) begin
      bits = {h[15], 8'hff, m, 13'd0};
    end else begin
      bits = {h[15], {3'd0, ex} + EXP_REBIAS, m, 13'd0};
    end
    return bits;
  endfunction

  // float32 multiply, round to nearest even
  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
    logic [7:0] ea, eb, ef;
    logic [23:0] ma, mb;
    logic [47:0] p, pn;
    logic [5:0] lz;
    logic signed [10:0] e;
    logic signed [10:0] amt;
    logic st, g, inc;
    logic [30:0] mag;
    logic [31:0] r;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    s = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    p = 48'(ma) * 48'(mb);
    lz = lzc48(p);
    pn = p << lz;
    e = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126 - $signed({5'd0, lz});
    st = 1'b0;
    if (e <= 11'sd0) begin
      amt = 11'sd1 - e;
      if (amt > 11'sd47) begin
        st = |pn;
        pn = 48'd0;
      end else begin
        st = |(pn & ((48'd1 << amt[5:0]) - 48'd1));
        pn = pn >> amt[5:0];
      end
      e = 11'sd0;
    end
    ef = pn[47] ? e[7:0] : 8'd0;
    g = pn[23];
    st = st | (|pn[22:0]);
    mag = {ef, pn[46:24]};
    inc = g & (st | mag[0]);
    mag = mag + 31'(inc);
    if (e >= 11'sd255) mag = F32_EXP_ALL[30:0];
    r = {s, mag};
    if (a_nan) r = a | F32_QBIT;
    else if (b_nan) r = b | F32_QBIT;
    else if ((a_inf && b_zero) || (a_zero && b_inf)) r = F32_QNAN_DEF;
    else if (a_inf || b_inf) r = {s, F32_EXP_ALL[30:0]};
    else if (a_zero || b_zero) r = {s, 31'd0};
    return r;
  endfunction

  // float32 add, round to nearest even
  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic a_nan, b_nan, a_inf, b_inf, sa, sb;
    logic [31:0] x, y, r;
    logic [7:0] ex, ey, d, ef;
    logic [26:0] mx, my, mys;
    logic [27:0] sm;
    logic [5:0] lz, shamt;
    logic [8:0] e;
    logic st, g, inc;
    logic [30:0] mag;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    sa = x[31];
    sb = y[31];
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {(x[30:23] != 8'd0), x[22:0], 3'd0};
    my = {(y[30:23] != 8'd0), y[22:0], 3'd0};
    d = ex - ey;
    if (d > 8'd26) begin
      mys = {26'd0, |my};
    end else begin
      mys = (my >> d[4:0]) | {26'd0, |(my & ((27'd1 << d[4:0]) - 27'd1))};
    end
    sm = (sa == sb) ? ({1'b0, mx} + {1'b0, mys}) : ({1'b0, mx} - {1'b0, mys});
    e = {1'b0, ex};
    if (sm[27]) begin
      sm = {1'b0, sm[27:2], sm[1] | sm[0]};
      e = e + 9'd1;
    end else begin
      lz = lzc48({sm[26:0], 21'd0});
      shamt = ({2'd0, lz} < (ex - 8'd1)) ? lz : 6'(ex - 8'd1);
      sm = sm << shamt;
      e = e - {3'd0, shamt};
    end
    ef = sm[26] ? e[7:0] : 8'd0;
    g = sm[2];
    st = |sm[1:0];
    mag = {ef, sm[25:3]};
    inc = g & (st | mag[0]);
    mag = mag + 31'(inc);
    if (e >= 9'd255) mag = F32_EXP_ALL[30:0];
    r = {sa, mag};
    if (sm == 28'd0) r = {(sa == sb) ? sa : 1'b0, 31'd0};
    if (a_nan) r = a | F32_QBIT;
    else if (b_nan) r = b | F32_QBIT;
    else if (a_inf && b_inf && (a[31] != b[31])) r = F32_QNAN_DEF;
    else if (a_inf) r = a;
    else if (b_inf) r = b;
    return r;
  endfunction

endpackage

// ===== design/q2bqdp_ctrl.sv =====
// Controller: sequences the per-element multiply, multiply, add steps of one word.
`timescale 1ns / 1ps
module q2bqdp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  q2bqdp_pkg::dp_stat_t  stat,
  output q2bqdp_pkg::dp_cmd_t   cmd
);

  q2bqdp_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= q2bqdp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      q2bqdp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = q2bqdp_pkg::ST_MUL_SCALE;
      end
      q2bqdp_pkg::ST_MUL_SCALE: state_nxt = q2bqdp_pkg::ST_MUL_ACT;
      q2bqdp_pkg::ST_MUL_ACT:   state_nxt = q2bqdp_pkg::ST_ADD;
      q2bqdp_pkg::ST_ADD: begin
        state_nxt = stat.last_elem ? q2bqdp_pkg::ST_DONE : q2bqdp_pkg::ST_MUL_SCALE;
      end
      q2bqdp_pkg::ST_DONE: begin
        if (!stat.row_end || stat.out_free) state_nxt = q2bqdp_pkg::ST_IDLE;
      end
      default: state_nxt = q2bqdp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      q2bqdp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      q2bqdp_pkg::ST_MUL_SCALE: cmd.mul_scale = 1'b1;
      q2bqdp_pkg::ST_MUL_ACT:   cmd.mul_act = 1'b1;
      q2bqdp_pkg::ST_ADD:       cmd.add = 1'b1;
      q2bqdp_pkg::ST_DONE:      cmd.emit = stat.row_end && stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/q2bqdp_dp.sv =====
// Datapath: word capture, shared float32 multiplier and adder, accumulator, output register.
`timescale 1ns / 1ps
module q2bqdp_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q2bqdp_pkg::dp_cmd_t   cmd,
  output q2bqdp_pkg::dp_stat_t  stat,
  input  logic [15:0]           in_group_scale,
  input  logic [7:0]            in_code_byte,
  input  logic [31:0]           in_act_first,
  input  logic [31:0]           in_act_second,
  input  logic [31:0]           in_act_third,
  input  logic [31:0]           in_act_fourth,
  input  logic                  in_row_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_dot_sum
);

  logic [31:0] scale_r;
  logic [7:0]  codes_r;
  logic [31:0] act_r [4];
  logic        row_end_r;
  logic [1:0]  idx_r;
  logic [31:0] tmp_r;
  logic [31:0] sum_r;
  logic [31:0] out_r;
  logic        out_valid_r;
  logic [1:0]  code;
  logic [31:0] act;

  // Current element operands
  assign code = codes_r[{idx_r, 1'b0} +: 2];
  assign act  = act_r[idx_r];

  // Captured word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scale_r   <= q2bqdp_pkg::half_to_f32(in_group_scale);
      codes_r   <= in_code_byte;
      act_r[0]  <= in_act_first;
      act_r[1]  <= in_act_second;
      act_r[2]  <= in_act_third;
      act_r[3]  <= in_act_fourth;
      row_end_r <= in_row_end;
    end
  end

  // Product register: scaled weight, then product
  always_ff @(posedge clk) begin
    if (cmd.mul_scale) begin
      tmp_r <= q2bqdp_pkg::f32_mul(scale_r, q2bqdp_pkg::code_weight(code));
    end else if (cmd.mul_act) begin
      tmp_r <= q2bqdp_pkg::f32_mul(tmp_r, act);
    end
  end

  // Element index and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      sum_r <= 32'd0;
    end else begin
      if (cmd.load) idx_r <= 2'd0;
      else if (cmd.add) idx_r <= idx_r + 2'd1;
      if (cmd.add) sum_r <= q2bqdp_pkg::f32_add(sum_r, tmp_r);
      else if (cmd.emit) sum_r <= 32'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | (out_valid_r & ~out_ready);
    end
    if (cmd.emit) out_r <= sum_r;
  end

  assign stat.last_elem = (idx_r == 2'd3);
  assign stat.row_end   = row_end_r;
  assign stat.out_free  = ~out_valid_r | out_ready;
  assign out_valid      = out_valid_r;
  assign out_dot_sum    = out_r;

endmodule

// ===== design/q2_block_quant_dot_product_top.sv =====
// Top level of the two-bit block-quantized dot product.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) carries one word: an fp16 group scale, a
//  byte of four 2-bit weight codes, four float32 activations and a row_end flag.
//  Each weight is (code - 1) * scale; the four products are added into a float32
//  accumulator in element order, every multiply and add rounded to nearest even.
//  When row_end is set the finished sum leaves on the output channel
//  (out_valid/out_ready, out_dot_sum) and the accumulator returns to +0.
//  Steps: accept a word in the idle state; for each element, scale times weight,
//  times activation, add, through the single shared multiplier and adder; then
//  a finish state that loads a row's sum into the output register. No new word
//  is taken before that. in_ready is high only while the block waits for a word.
//  A held result sits in the output register while the next words are taken;
//  a row end that finds that register still full waits until it is read.
//  Reset (rst_n low, synchronous) clears the accumulator to +0 and drops
//  out_valid.
module q2_block_quant_dot_product_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_group_scale,
  input  logic [7:0]  in_code_byte,
  input  logic [31:0] in_act_first,
  input  logic [31:0] in_act_second,
  input  logic [31:0] in_act_third,
  input  logic [31:0] in_act_fourth,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_dot_sum
);

  q2bqdp_pkg::dp_cmd_t  cmd;
  q2bqdp_pkg::dp_stat_t stat;

  q2bqdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  q2bqdp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_group_scale (in_group_scale),
    .in_code_byte   (in_code_byte),
    .in_act_first   (in_act_first),
    .in_act_second  (in_act_second),
    .in_act_third   (in_act_third),
    .in_act_fourth  (in_act_fourth),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dot_sum    (out_dot_sum)
  );

`ifndef SYNTHESIS
  // One word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while another is in flight");

  // A result is never written over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Emitting a result raises out_valid next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  // The datapath loads only on an accepted word
  a_load_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && in_ready))
    else $error("word loaded without handshake");
`endif

endmodule
